// ===== rtl/psu_pkg.sv =====
// Shared types and constants for the PNG scanline unfilter.
`timescale 1ns / 1ps
`default_nettype none

package psu_pkg;

  localparam int unsigned MAX_ROW_PIXELS_DEF = 4096;
  localparam int unsigned ROW_PIXELS_W       = 13;
  localparam int unsigned CFG_IDX_W          = 1;
  localparam int unsigned CFG_DATA_W         = ROW_PIXELS_W;

  localparam logic                    HAS_ALPHA_RST  = 1'b1;
  localparam logic [ROW_PIXELS_W-1:0] ROW_PIXELS_RST = ROW_PIXELS_W'(4096);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HAS_ALPHA  = 1'b0,
    REG_ROW_PIXELS = 1'b1
  } psu_reg_e;

  // Filter types as they appear in the stream.
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } psu_filt_e;

  // What an accepted byte turns into once it has been classified.
  typedef enum logic [1:0] {
    KIND_FILTER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_ERROR  = 2'd2
  } psu_kind_e;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       image_start;
  } psu_in_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       status;
  } psu_out_t;

  // Classified item handed from the sequencer to the reconstruction stage.
  typedef struct packed {
    psu_kind_e  kind;
    psu_filt_e  filter;
    logic [1:0] ch;
    logic       row_end;
    logic       first_row;
    logic [7:0] stream_byte;
  } psu_item_t;

endpackage

`default_nettype wire

// ===== rtl/psu_line_buf.sv =====
// Line store holding the previous row, with a fill mark for never-written entries.
`timescale 1ns / 1ps
`default_nettype none

module psu_line_buf #(
  parameter int unsigned MAX_ROW_PIXELS = psu_pkg::MAX_ROW_PIXELS_DEF,
  localparam int unsigned LINE_DEPTH = MAX_ROW_PIXELS * 4,
  localparam int unsigned ADDR_W     = $clog2(LINE_DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [7:0]        wr_data_i,
  output logic      [7:0]        up_o
);

  localparam int unsigned FILL_W = $clog2(LINE_DEPTH + 1);

  logic [7:0]        mem [LINE_DEPTH];
  logic [7:0]        rd_data_q;
  logic              rd_hit_q, rd_hit_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  // Rows are always written from column zero upwards, so the written entries
  // form one contiguous range starting at zero and a single mark covers them.
  always_comb begin
    fill_d = fill_q;
    if (wr_en_i && (FILL_W'(wr_addr_i) >= fill_q)) begin
      fill_d = FILL_W'(wr_addr_i) + FILL_W'(1);
    end
  end

  assign rd_hit_d = rd_en_i ? (FILL_W'(rd_addr_i) < fill_q) : rd_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      rd_hit_q <= rd_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign up_o = rd_hit_q ? rd_data_q : 8'd0;

  a_no_same_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en_i && wr_en_i) |-> (rd_addr_i != wr_addr_i))
    else $error("line store read and write collide on one address");

endmodule

`default_nettype wire

// ===== rtl/psu_ctrl.sv =====
// Row sequencer: configuration registers, filter byte handling and column tracking.
`timescale 1ns / 1ps
`default_nettype none

module psu_ctrl #(
  parameter int unsigned MAX_ROW_PIXELS = psu_pkg::MAX_ROW_PIXELS_DEF,
  localparam int unsigned COL_W = $clog2(MAX_ROW_PIXELS * 4)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [psu_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [psu_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                in_valid_i,
  input  wire logic                                in_ready_i,
  input  wire psu_pkg::psu_in_t                    in_data_i,
  output logic                                     item_valid_o,
  output psu_pkg::psu_item_t                       item_o,
  output logic      [COL_W-1:0]                    col_o,
  output logic                                     rd_en_o
);

  import psu_pkg::*;

  localparam int unsigned PIX_W = $clog2(MAX_ROW_PIXELS + 1);
  localparam int unsigned LEN_W = $clog2(MAX_ROW_PIXELS * 4 + 1);

  logic                    has_alpha_q;
  logic [ROW_PIXELS_W-1:0] row_pixels_q;
  logic                    halted_q, halted_d;
  logic                    expect_q, expect_d;
  logic                    first_q, first_d;
  psu_filt_e               filter_q, filter_d;
  logic [COL_W-1:0]        column_q, column_d;
  logic [1:0]              mod3_q, mod3_d;

  logic             accept;
  logic             drop;
  logic             halted_eff, expect_eff, first_eff;
  psu_kind_e        kind;
  logic [PIX_W-1:0] pixels;
  logic [LEN_W-1:0] row_len;
  logic             is_end;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_alpha_q  <= HAS_ALPHA_RST;
      row_pixels_q <= ROW_PIXELS_RST;
    end else if (cfg_valid_i) begin
      unique case (psu_reg_e'(cfg_index_i))
        REG_HAS_ALPHA:  has_alpha_q  <= cfg_data_i[0];
        REG_ROW_PIXELS: row_pixels_q <= cfg_data_i[ROW_PIXELS_W-1:0];
        default: ;
      endcase
    end
  end

  // Width clamped to 1..MAX_ROW_PIXELS; row length is 3 or 4 bytes a pixel.
  always_comb begin
    if (row_pixels_q == '0) begin
      pixels = PIX_W'(1);
    end else if (32'(row_pixels_q) > 32'(MAX_ROW_PIXELS)) begin
      pixels = PIX_W'(MAX_ROW_PIXELS);
    end else begin
      pixels = PIX_W'(row_pixels_q);
    end
    if (has_alpha_q) begin
      row_len = LEN_W'(pixels) << 2;
    end else begin
      row_len = LEN_W'(pixels) + (LEN_W'(pixels) << 1);
    end
  end

  assign is_end = (LEN_W'(column_q) + LEN_W'(1)) >= row_len;
  assign accept = in_valid_i && in_ready_i;

  always_comb begin
    halted_eff = halted_q && !in_data_i.image_start;
    expect_eff = expect_q || in_data_i.image_start;
    first_eff  = first_q || in_data_i.image_start;
    drop       = 1'b0;
    kind       = KIND_DATA;
    priority if (halted_eff) begin
      drop = 1'b1;
    end else if (expect_eff) begin
      if (in_data_i.stream_byte > 8'(FILT_PAETH)) begin
        kind = KIND_ERROR;
      end else begin
        kind = KIND_FILTER;
      end
    end else begin
      kind = KIND_DATA;
    end

    halted_d = halted_q;
    expect_d = expect_q;
    first_d  = first_q;
    filter_d = filter_q;
    column_d = column_q;
    mod3_d   = mod3_q;
    if (accept) begin
      halted_d = halted_eff;
      expect_d = expect_eff;
      first_d  = first_eff;
      if (!drop) begin
        unique case (kind)
          KIND_ERROR: begin
            halted_d = 1'b1;
          end
          KIND_FILTER: begin
            filter_d = psu_filt_e'(in_data_i.stream_byte[2:0]);
            expect_d = 1'b0;
            column_d = '0;
            mod3_d   = 2'd0;
          end
          KIND_DATA: begin
            if (is_end) begin
              expect_d = 1'b1;
              first_d  = 1'b0;
              column_d = '0;
              mod3_d   = 2'd0;
            end else begin
              column_d = column_q + COL_W'(1);
              mod3_d   = (mod3_q == 2'd2) ? 2'd0 : mod3_q + 2'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q <= 1'b0;
      expect_q <= 1'b1;
      first_q  <= 1'b1;
      filter_q <= FILT_NONE;
      column_q <= '0;
      mod3_q   <= 2'd0;
    end else begin
      halted_q <= halted_d;
      expect_q <= expect_d;
      first_q  <= first_d;
      filter_q <= filter_d;
      column_q <= column_d;
      mod3_q   <= mod3_d;
    end
  end

  always_comb begin
    item_o.kind        = kind;
    item_o.filter      = filter_q;
    item_o.ch          = has_alpha_q ? column_q[1:0] : mod3_q;
    item_o.row_end     = is_end;
    item_o.first_row   = first_eff;
    item_o.stream_byte = in_data_i.stream_byte;
  end

  assign item_valid_o = in_valid_i && !drop;
  assign col_o        = column_q;
  assign rd_en_o      = accept && !drop && (kind == KIND_DATA);

  a_rgb_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en_o && !has_alpha_q) |-> (item_o.ch != 2'd3))
    else $error("channel index out of range for three bytes per pixel");

  a_halt_after_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !drop && (kind == KIND_ERROR)) |=> halted_q)
    else $error("unknown filter type did not halt the image");

  a_mod3_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (mod3_q != 2'd3))
    else $error("modulo-three column counter left its range");

endmodule

`default_nettype wire

// ===== rtl/psu_recon.sv =====
// Reconstruction stage: item register, filter arithmetic and result register.
`timescale 1ns / 1ps
`default_nettype none

module psu_recon #(
  parameter int unsigned MAX_ROW_PIXELS = psu_pkg::MAX_ROW_PIXELS_DEF,
  localparam int unsigned COL_W = $clog2(MAX_ROW_PIXELS * 4)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     item_valid_i,
  input  wire psu_pkg::psu_item_t       item_i,
  input  wire logic      [COL_W-1:0]    col_i,
  output logic                          ready_o,
  input  wire logic      [7:0]          up_i,
  output logic                          wr_en_o,
  output logic           [COL_W-1:0]    wr_addr_o,
  output logic           [7:0]          wr_data_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output psu_pkg::psu_out_t             out_data_o
);

  import psu_pkg::*;

  logic             s1_valid_q, s1_valid_d;
  psu_item_t        s1_item_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_fire;
  logic             load;

  logic [7:0] left_q [4];
  logic [7:0] ul_q   [4];

  logic             out_valid_q, out_valid_d;
  psu_out_t         out_q, out_d;

  logic [7:0]        left, ul, up, pred, value;
  logic [8:0]        avg_sum;
  logic signed [9:0] pa_s, pb_s, pc_s;
  logic [9:0]        pa, pb, pc;

  assign s1_fire = s1_valid_q &&
                   ((s1_item_q.kind == KIND_FILTER) || !out_valid_q || out_ready_i);
  assign ready_o = !s1_valid_q || s1_fire;
  assign load    = item_valid_i && ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (load) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_item_q <= item_i;
      s1_col_q  <= col_i;
    end
  end

  assign left = left_q[s1_item_q.ch];
  assign ul   = ul_q[s1_item_q.ch];
  assign up   = s1_item_q.first_row ? 8'd0 : up_i;

  // Paeth distances: |up-ul|, |left-ul| and |left+up-2*ul|.
  always_comb begin
    pa_s    = 10'(signed'({2'b00, up})) - 10'(signed'({2'b00, ul}));
    pb_s    = 10'(signed'({2'b00, left})) - 10'(signed'({2'b00, ul}));
    pc_s    = pa_s + pb_s;
    pa      = pa_s[9] ? 10'(-pa_s) : 10'(pa_s);
    pb      = pb_s[9] ? 10'(-pb_s) : 10'(pb_s);
    pc      = pc_s[9] ? 10'(-pc_s) : 10'(pc_s);
    avg_sum = 9'(left) + 9'(up);
    unique case (s1_item_q.filter)
      FILT_SUB:   pred = left;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: begin
        priority if ((pa <= pb) && (pa <= pc)) begin
          pred = left;
        end else if (pb <= pc) begin
          pred = up;
        end else begin
          pred = ul;
        end
      end
      default:    pred = 8'd0;
    endcase
    value = s1_item_q.stream_byte + pred;
  end

  // A filter byte opens a new row and clears the neighbours of the first pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        left_q[i] <= 8'd0;
        ul_q[i]   <= 8'd0;
      end
    end else if (s1_fire) begin
      if (s1_item_q.kind == KIND_FILTER) begin
        for (int i = 0; i < 4; i++) begin
          left_q[i] <= 8'd0;
          ul_q[i]   <= 8'd0;
        end
      end else if (s1_item_q.kind == KIND_DATA) begin
        left_q[s1_item_q.ch] <= value;
        ul_q[s1_item_q.ch]   <= up;
      end
    end
  end

  assign wr_en_o   = s1_fire && (s1_item_q.kind == KIND_DATA);
  assign wr_addr_o = s1_col_q;
  assign wr_data_o = value;

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (s1_fire) begin
      unique case (s1_item_q.kind)
        KIND_DATA: begin
          out_valid_d      = 1'b1;
          out_d.pixel_byte = value;
          out_d.row_end    = s1_item_q.row_end;
          out_d.status     = 1'b0;
        end
        KIND_ERROR: begin
          out_valid_d      = 1'b1;
          out_d.pixel_byte = 8'd0;
          out_d.row_end    = 1'b0;
          out_d.status     = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_error_result_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status) |-> ((out_q.pixel_byte == 8'd0) && !out_q.row_end))
    else $error("error result carries pixel data or a row end");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !wr_en_o)
    else $error("data item retired while the result register was full");

endmodule

`default_nettype wire

// ===== rtl/png_scanline_unfilter_top.sv =====
// Top level of the PNG scanline unfilter (filter reconstruction for RGB and RGBA rows).
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+-----------------------------------
//  in      | sink      | in_valid_i / in_ready_o | psu_in_t: stream_byte, image_start
//  out     | source    | out_valid_o/out_ready_i | psu_out_t: pixel_byte, row_end, status
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One byte a cycle is taken unless the output stalls; a byte passes the item register,
// then its result enters the result register; Sub, Avg and Paeth loop through left_q.
// The line store is a single-port-write, single-read memory; its read is issued as the
// byte is accepted, and a fill mark makes never-written entries read as zero, so no
// clearing pass follows reset. Configuration is always taken (cfg_ready_o is high).
// When the result register is full and not taken, the input stage holds its byte and
// in_ready_o drops; filter bytes and dropped bytes still flow while the output stalls,
// until a byte that needs the result register reaches the input stage.
`timescale 1ns / 1ps
`default_nettype none

module png_scanline_unfilter_top #(
  parameter int unsigned MAX_ROW_PIXELS = psu_pkg::MAX_ROW_PIXELS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [psu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire psu_pkg::psu_in_t               in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output psu_pkg::psu_out_t                   out_data_o
);

  import psu_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_ROW_PIXELS * 4);

  logic             item_valid;
  psu_item_t        item;
  logic [COL_W-1:0] col;
  logic             rd_en;
  logic             wr_en;
  logic [COL_W-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic [7:0]       up;

  psu_ctrl #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .item_valid_o(item_valid),
    .item_o      (item),
    .col_o       (col),
    .rd_en_o     (rd_en)
  );

  psu_line_buf #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
  ) u_line_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(col),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .up_o     (up)
  );

  psu_recon #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
  ) u_recon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_i      (item),
    .col_i       (col),
    .ready_o     (in_ready_o),
    .up_i        (up),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
